### rtl/linear_interp_pcm_resampler_macros.svh
// Assertion helpers used by the resampler top level.
`ifndef LINEAR_INTERP_PCM_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_PCM_RESAMPLER_MACROS_SVH

// Checks an implication that must hold at every rising edge outside reset.
`define LIPR_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a condition that must hold in the cycle after a trigger.
`define LIPR_CHECK_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

### rtl/lipr_pkg.sv
`timescale 1ns / 1ps

package lipr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 21;
    localparam int GAIN_W     = 16;
    localparam int LANE_LAT   = 3;
    localparam int FIFO_DEPTH = 4;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

    typedef enum logic [1:0] {
        CFG_SIXTEEN_BIT,
        CFG_STEREO,
        CFG_POSITION_STEP,
        CFG_VOLUME_GAIN
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic run_last;
        logic sound_done;
    } issue_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       run_last;
        logic                       sound_done;
    } result_t;

endpackage

### rtl/lipr_lane.sv
`timescale 1ns / 1ps

module lipr_lane #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0] held,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0] fresh,
    input  logic [PHASE_FRAC_BITS-1:0]           frac,
    input  logic [lipr_pkg::GAIN_W-1:0]          gain,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] value
);
    import lipr_pkg::*;

    localparam int AW    = PHASE_FRAC_BITS + SAMPLE_W + 2;
    localparam int SHIFT = PHASE_FRAC_BITS - 8;
    localparam int A8_W  = 25;
    localparam int M_W   = A8_W + GAIN_W + 1;
    localparam int Q_W   = M_W + 15;
    localparam int DROP  = 38;
    localparam int V_W   = Q_W - DROP;

    localparam logic signed [V_W-1:0] V_MAX = V_W'(32767);
    localparam logic signed [V_W-1:0] V_MIN = -V_W'(32768);
    localparam logic signed [AW-1:0]  A_MASK = (AW'(1) << SHIFT) - AW'(1);
    localparam logic signed [Q_W-1:0] Q_MASK = (Q_W'(1) << DROP) - Q_W'(1);

    logic signed [SAMPLE_W:0]    diff;
    logic signed [AW-1:0]        base;
    logic signed [AW-1:0]        prod;
    logic signed [AW-1:0]        acc_next;
    logic signed [AW-1:0]        acc_reg;
    logic signed [AW-1:0]        acc_adj;
    logic signed [AW-1:0]        acc_shift;
    logic signed [A8_W-1:0]      a8;
    logic signed [M_W-1:0]       m_next;
    logic signed [M_W-1:0]       m_reg;
    logic signed [Q_W-1:0]       m_ext;
    logic signed [Q_W-1:0]       q;
    logic signed [Q_W-1:0]       q_adj;
    logic signed [Q_W-1:0]       q_shift;
    logic signed [V_W-1:0]       v;
    logic signed [SAMPLE_W-1:0]  value_next;
    logic signed [SAMPLE_W-1:0]  value_reg;

    always_comb
    begin
        diff     = $signed({fresh[SAMPLE_W-1], fresh}) - $signed({held[SAMPLE_W-1], held});
        base     = $signed({{2{held[SAMPLE_W-1]}}, held, {PHASE_FRAC_BITS{1'b0}}});
        prod     = diff * $signed({1'b0, frac});
        acc_next = base + prod;
    end

    always_comb
    begin
        acc_adj   = acc_reg + (acc_reg[AW-1] ? A_MASK : '0);
        acc_shift = acc_adj >>> SHIFT;
        a8        = $signed(acc_shift[A8_W-1:0]);
        m_next    = a8 * $signed({1'b0, gain});
    end

    always_comb
    begin
        m_ext   = $signed({{(Q_W-M_W){m_reg[M_W-1]}}, m_reg});
        q       = (m_ext <<< 15) - m_ext;
        q_adj   = q + (q[Q_W-1] ? Q_MASK : '0);
        q_shift = q_adj >>> DROP;
        v       = $signed(q_shift[V_W-1:0]);
        if (v > V_MAX)
        begin
            value_next = 16'sh7FFF;
        end
        else if (v < V_MIN)
        begin
            value_next = 16'sh8000;
        end
        else
        begin
            value_next = $signed(v[SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        m_reg     <= m_next;
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/lipr_ctrl.sv
`timescale 1ns / 1ps

module lipr_ctrl #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sixteen_bit_mode,
    input  logic                                 stereo_mode,
    input  logic [lipr_pkg::CFG_W-1:0]           position_step,
    input  logic [lipr_pkg::SAMPLE_W-1:0]        raw_left,
    input  logic [lipr_pkg::SAMPLE_W-1:0]        raw_right,
    input  logic                                 first_frame,
    input  logic                                 final_frame,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 issue_ok,
    output lipr_pkg::issue_t                     issue,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] held_left,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] held_right,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] fresh_left,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] fresh_right,
    output logic [PHASE_FRAC_BITS-1:0]           frac
);
    import lipr_pkg::*;

    localparam int PW = PHASE_FRAC_BITS + 5;
    localparam int CW = (PW > CFG_W) ? PW : CFG_W;

    localparam logic [CW-1:0] STEP_LO = CW'(1) << (PHASE_FRAC_BITS - 5);
    localparam logic [CW-1:0] STEP_HI = CW'(1) << (PHASE_FRAC_BITS + 4);
    localparam logic [PW-1:0] ONE     = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [PW:0]   ONE_X   = (PW + 1)'(1) << PHASE_FRAC_BITS;
    localparam logic [PW:0]   TWO_X   = (PW + 1)'(1) << (PHASE_FRAC_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_HOLD
    } state_t;

    state_t                     state_reg, state_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic signed [SAMPLE_W-1:0] held_l_reg, held_l_next;
    logic signed [SAMPLE_W-1:0] held_r_reg, held_r_next;
    logic signed [SAMPLE_W-1:0] fresh_l_reg, fresh_l_next;
    logic signed [SAMPLE_W-1:0] fresh_r_reg, fresh_r_next;
    logic                       held_valid_reg, held_valid_next;
    logic                       final_reg, final_next;

    logic [CW-1:0]              step_ext;
    logic [PW-1:0]              step;
    logic [PW:0]                sum;
    logic                       pos_lt_one;
    logic signed [SAMPLE_W-1:0] dec_l;
    logic signed [SAMPLE_W-1:0] dec_r;

    function automatic logic signed [SAMPLE_W-1:0] decode(
        input logic [SAMPLE_W-1:0] raw,
        input logic                wide
    );
        if (wide)
        begin
            return $signed(raw);
        end
        return $signed({~raw[7], raw[6:0], 8'h00});
    endfunction

    always_comb
    begin
        step_ext = CW'(position_step);
        if (step_ext < STEP_LO)
        begin
            step = PW'(STEP_LO);
        end
        else if (step_ext > STEP_HI)
        begin
            step = PW'(STEP_HI);
        end
        else
        begin
            step = PW'(step_ext);
        end
    end

    always_comb
    begin
        dec_l      = decode(raw_left, sixteen_bit_mode);
        dec_r      = stereo_mode ? decode(raw_right, sixteen_bit_mode) : dec_l;
        sum        = {1'b0, pos_reg} + {1'b0, step};
        pos_lt_one = pos_reg < ONE;

        state_next      = state_reg;
        pos_next        = pos_reg;
        held_l_next     = held_l_reg;
        held_r_next     = held_r_reg;
        fresh_l_next    = fresh_l_reg;
        fresh_r_next    = fresh_r_reg;
        held_valid_next = held_valid_reg;
        final_next      = final_reg;
        issue           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    fresh_l_next = dec_l;
                    fresh_r_next = dec_r;
                    final_next   = final_frame;
                    if (first_frame || !held_valid_reg)
                    begin
                        held_l_next     = dec_l;
                        held_r_next     = dec_r;
                        held_valid_next = 1'b1;
                        pos_next        = '0;
                        if (final_frame)
                        begin
                            state_next = ST_HOLD;
                        end
                    end
                    else
                    begin
                        state_next = ST_INTERP;
                    end
                end
            end
            ST_INTERP:
            begin
                if (pos_lt_one)
                begin
                    if (issue_ok)
                    begin
                        issue.valid      = 1'b1;
                        issue.run_last   = (sum >= ONE_X) && (!final_reg || sum >= TWO_X);
                        issue.sound_done = final_reg && (sum >= TWO_X);
                        pos_next         = PW'(sum);
                    end
                end
                else
                begin
                    pos_next        = pos_reg - ONE;
                    held_l_next     = fresh_l_reg;
                    held_r_next     = fresh_r_reg;
                    held_valid_next = 1'b1;
                    state_next      = final_reg ? ST_HOLD : ST_IDLE;
                end
            end
            ST_HOLD:
            begin
                if (pos_lt_one)
                begin
                    if (issue_ok)
                    begin
                        issue.valid      = 1'b1;
                        issue.run_last   = sum >= ONE_X;
                        issue.sound_done = sum >= ONE_X;
                        pos_next         = PW'(sum);
                    end
                end
                else
                begin
                    pos_next        = '0;
                    held_l_next     = '0;
                    held_r_next     = '0;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            held_l_reg     <= '0;
            held_r_reg     <= '0;
            fresh_l_reg    <= '0;
            fresh_r_reg    <= '0;
            held_valid_reg <= 1'b0;
            final_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            held_l_reg     <= held_l_next;
            held_r_reg     <= held_r_next;
            fresh_l_reg    <= fresh_l_next;
            fresh_r_reg    <= fresh_r_next;
            held_valid_reg <= held_valid_next;
            final_reg      <= final_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign held_left   = held_l_reg;
    assign held_right  = held_r_reg;
    assign fresh_left  = fresh_l_reg;
    assign fresh_right = fresh_r_reg;
    assign frac        = pos_reg[PHASE_FRAC_BITS-1:0];

endmodule

### rtl/lipr_merge.sv
`timescale 1ns / 1ps

module lipr_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lipr_pkg::issue_t                     issue,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0] lane_left,
    input  logic signed [lipr_pkg::SAMPLE_W-1:0] lane_right,
    output logic                                 issue_ok,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] out_right,
    output logic                                 run_last,
    output logic                                 sound_done
);
    import lipr_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W = CNT_W + 1;

    issue_t        tag_reg [LANE_LAT];
    result_t       fifo_mem [FIFO_DEPTH];
    result_t       head;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [OCC_W-1:0] occupancy;
    logic             push;
    logic             pop;

    always_comb
    begin
        occupancy = OCC_W'(count_reg);
        for (int i = 0; i < LANE_LAT; i++)
        begin
            occupancy = occupancy + OCC_W'(tag_reg[i].valid);
        end
        push     = tag_reg[LANE_LAT-1].valid;
        pop      = out_valid && !out_stall;
        issue_ok = (occupancy - OCC_W'(pop)) < OCC_W'(FIFO_DEPTH);

        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            tag_reg[0] <= issue;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{left:       lane_left,
                                      right:      lane_right,
                                      run_last:   tag_reg[LANE_LAT-1].run_last,
                                      sound_done: tag_reg[LANE_LAT-1].sound_done};
        end
    end

    assign head       = fifo_mem[rd_ptr_reg];
    assign out_valid  = (count_reg != '0);
    assign out_left   = head.left;
    assign out_right  = head.right;
    assign run_last   = head.run_last;
    assign sound_done = head.sound_done;

endmodule

### rtl/linear_interp_pcm_resampler.sv
`timescale 1ns / 1ps

// Linear-interpolation PCM resampler. Source frames enter on the input channel
// (raw_left, raw_right, first_frame, final_frame with in_valid and in_stall) and
// stereo output words leave on the output channel (out_left, out_right, run_last,
// sound_done with out_valid and out_stall). The four settings are written through
// cfg_wr_en, cfg_index and cfg_wr_data; the user must write them only while no
// word is in progress, as the block itself does not enforce this. A frame that
// starts a sound only loads the held sample. A frame that continues a sound moves
// the controller to interpolation, where it issues each output word it causes and
// then closes the interval. A final frame adds a hold run of words and closes that
// run too, so a frame that both starts and ends a sound gives only its hold words.
// The controller issues at most one output position per cycle; two lanes, one per
// channel, compute the interpolated samples in three pipeline stages each.
// Each output word passes through the lane stages and then the output queue.
// A four-word output queue lets the controller finish a frame and take the next one
// while earlier words still wait; when the receiver stalls, the queue fills and the
// controller pauses issuing until space returns, so no word is lost.
// Reset empties the queue, drops any held frame and restores the default settings:
// 16-bit stereo samples, unity step and unity gain.

`include "linear_interp_pcm_resampler_macros.svh"

module linear_interp_pcm_resampler #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  lipr_pkg::cfg_idx_t                   cfg_index,
    input  logic [lipr_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lipr_pkg::SAMPLE_W-1:0]        raw_left,
    input  logic [lipr_pkg::SAMPLE_W-1:0]        raw_right,
    input  logic                                 first_frame,
    input  logic                                 final_frame,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [lipr_pkg::SAMPLE_W-1:0] out_right,
    output logic                                 run_last,
    output logic                                 sound_done
);
    import lipr_pkg::*;

    logic                       sixteen_bit_reg;
    logic                       stereo_reg;
    logic [CFG_W-1:0]           step_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [GAIN_W-1:0]          gain_eff;

    issue_t                     issue;
    logic                       issue_ok;
    logic signed [SAMPLE_W-1:0] held_left;
    logic signed [SAMPLE_W-1:0] held_right;
    logic signed [SAMPLE_W-1:0] fresh_left;
    logic signed [SAMPLE_W-1:0] fresh_right;
    logic [PHASE_FRAC_BITS-1:0] frac;
    logic signed [SAMPLE_W-1:0] lane_left;
    logic signed [SAMPLE_W-1:0] lane_right;
    logic                       start_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sixteen_bit_reg <= 1'b1;
            stereo_reg      <= 1'b1;
            step_reg        <= CFG_W'(65536);
            gain_reg        <= UNITY_GAIN;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SIXTEEN_BIT:   sixteen_bit_reg <= cfg_wr_data[0];
                CFG_STEREO:        stereo_reg      <= cfg_wr_data[0];
                CFG_POSITION_STEP: step_reg        <= cfg_wr_data;
                CFG_VOLUME_GAIN:   gain_reg        <= cfg_wr_data[GAIN_W-1:0];
                default:           step_reg        <= step_reg;
            endcase
        end
    end

    assign gain_eff = (gain_reg > UNITY_GAIN) ? UNITY_GAIN : gain_reg;

    lipr_ctrl #(
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .sixteen_bit_mode (sixteen_bit_reg),
        .stereo_mode      (stereo_reg),
        .position_step    (step_reg),
        .raw_left         (raw_left),
        .raw_right        (raw_right),
        .first_frame      (first_frame),
        .final_frame      (final_frame),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .issue_ok         (issue_ok),
        .issue            (issue),
        .held_left        (held_left),
        .held_right       (held_right),
        .fresh_left       (fresh_left),
        .fresh_right      (fresh_right),
        .frac             (frac)
    );

    lipr_lane #(
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_lane_left (
        .clk   (clk),
        .held  (held_left),
        .fresh (fresh_left),
        .frac  (frac),
        .gain  (gain_eff),
        .value (lane_left)
    );

    lipr_lane #(
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_lane_right (
        .clk   (clk),
        .held  (held_right),
        .fresh (fresh_right),
        .frac  (frac),
        .gain  (gain_eff),
        .value (lane_right)
    );

    lipr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .lane_left  (lane_left),
        .lane_right (lane_right),
        .issue_ok   (issue_ok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_left   (out_left),
        .out_right  (out_right),
        .run_last   (run_last),
        .sound_done (sound_done)
    );

    assign start_accept = in_valid && !in_stall && first_frame && !final_frame;

    `LIPR_CHECK(a_done_is_last, (out_valid && sound_done) |-> run_last, "sound_done alone")
    `LIPR_CHECK(a_issue_has_room, issue.valid |-> issue_ok, "position issued with a full queue")
    `LIPR_CHECK_NEXT(a_start_is_silent, start_accept, !issue.valid, "starting frame issued a word")

endmodule
